### rtl/core/tilt_compensated_heading_macros.svh
`ifndef TILT_COMPENSATED_HEADING_MACROS_SVH
`define TILT_COMPENSATED_HEADING_MACROS_SVH

// Both macros sample on clk and are held off while rst_n is low.
`define THC_ASSERT_IMP(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error(msg);

`define THC_ASSERT_NXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

### rtl/core/thc_pkg.sv
package thc_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 6;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ZFRAC = 20;
    localparam int TABLE_LEN = 24;
    localparam int ZW = 30;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_FULL_SCALE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADING_OFFSET = 4'd1;
    localparam logic [4:0] FULL_SCALE_RESET = 5'd2;

    localparam int RAD_W = 31;
    localparam int ROOT_W = 16;
    localparam int SQRT_STEPS = (RAD_W + 1) / 2;
    localparam int NUM_W = 31;
    localparam int QUO_W = 16;
    localparam int TILT_W = 48;
    localparam int PLAIN_W = 16;

    typedef struct packed {
        logic signed [16:0] ax;
        logic signed [16:0] ay;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] mz;
    } thc_s1_t;

    typedef struct packed {
        logic               flag;
        logic               use_div;
        logic               neg;
        logic [15:0]        cp;
        logic signed [16:0] sp;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] mz;
    } thc_s2_t;

    typedef struct packed {
        logic               flag;
        logic signed [16:0] sr;
        logic [15:0]        cp;
        logic signed [16:0] sp;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] mz;
    } thc_s3_t;

    // Arctangent of 2^-i in degrees, Q20.
    function automatic logic signed [ZW-1:0] atan_q20(input int idx);
        case (idx)
            0:       return 30'sd47185920;
            1:       return 30'sd27855475;
            2:       return 30'sd14718068;
            3:       return 30'sd7471121;
            4:       return 30'sd3750058;
            5:       return 30'sd1876857;
            6:       return 30'sd938658;
            7:       return 30'sd469357;
            8:       return 30'sd234682;
            9:       return 30'sd117342;
            10:      return 30'sd58672;
            11:      return 30'sd29335;
            12:      return 30'sd14668;
            13:      return 30'sd7334;
            14:      return 30'sd3667;
            15:      return 30'sd1833;
            16:      return 30'sd917;
            17:      return 30'sd458;
            18:      return 30'sd229;
            19:      return 30'sd115;
            20:      return 30'sd57;
            21:      return 30'sd29;
            22:      return 30'sd14;
            23:      return 30'sd7;
            default: return 30'sd0;
        endcase
    endfunction

endpackage

### rtl/core/tilt_compensated_heading.sv
// Tilt compensated compass heading.
// One word on the input channel carries a raw accelerometer sample and a raw
// magnetometer sample; one word on the output channel carries the tilt
// compensated heading, the plain heading and the roll flag, both headings in
// 1/2^ANGLE_FRAC_BITS degree within [0,360).
// The configuration channel is always ready and writes the full scale and the
// heading offset; write it only while no word is in flight.
// The datapath is a single pipeline: two square root chains, a divider and
// two CORDIC chains resolve one bit or one rotation per stage.
// A new word is accepted every cycle while the output is not stalled.
// When the receiver stalls a held output word, the whole pipeline freezes and
// in_ready falls until that word is taken; nothing is dropped or repeated.
// Reset clears every valid bit, sets the full scale to 2 g and the offset to 0.
`include "tilt_compensated_heading_macros.svh"

module tilt_compensated_heading
    import thc_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [15:0]    accel_x,
    input  logic signed [15:0]    accel_y,
    input  logic signed [15:0]    accel_z,
    input  logic signed [15:0]    mag_x,
    input  logic signed [15:0]    mag_y,
    input  logic signed [15:0]    mag_z,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [14:0]           tilt_heading,
    output logic [14:0]           plain_heading,
    output logic                  roll_forced_zero
);

    localparam int K = ZFRAC - ANGLE_FRAC_BITS;
    localparam int UW = ZW - K;
    localparam int SW = ((UW > 15) ? UW : 15) + 1;
    localparam int FULL = 360 * (2 ** ANGLE_FRAC_BITS);
    localparam int P = $clog2((2 ** (SW - 1) + FULL - 1) / FULL);
    localparam int RW = SW + 2;
    localparam int BIAS = FULL * (2 ** P);
    localparam logic signed [ZW-1:0] ROUND_HALF = ZW'(2 ** (K - 1));

    function automatic logic signed [16:0] clamp_q15(input logic signed [21:0] v);
        if (v > 22'sd32768)
            return 17'sd32768;
        if (v < -22'sd32768)
            return -17'sd32768;
        return 17'(v);
    endfunction

    function automatic logic [14:0] wrap_angle(input logic signed [SW-1:0] a);
        logic [RW-1:0] v;
        v = RW'(a) + RW'(BIAS);
        for (int j = P; j >= 0; j--)
        begin
            if (v >= RW'(FULL * (2 ** j)))
                v = v - RW'(FULL * (2 ** j));
        end
        return v[14:0];
    endfunction

    logic        en;
    logic [4:0]  fs_reg;
    logic signed [14:0] offset_reg;

    assign en = out_ready || !out_valid;
    assign in_ready = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg <= FULL_SCALE_RESET;
            offset_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ACCEL_FULL_SCALE: fs_reg <= cfg_data[4:0];
                REG_HEADING_OFFSET:   offset_reg <= cfg_data[14:0];
                default:              ;
            endcase
        end
    end

    // Scale and clamp the accelerometer.
    logic signed [21:0] ax_scaled;
    logic signed [21:0] ay_scaled;
    logic               s1_valid_reg;
    thc_s1_t            s1_reg;

    assign ax_scaled = 22'(accel_x) * 22'($signed({1'b0, fs_reg}));
    assign ay_scaled = 22'(accel_y) * 22'($signed({1'b0, fs_reg}));

    // Square of pitch sine feeding the cosine root.
    logic signed [33:0] ax_sq;
    logic               s2_valid_reg;
    logic [RAD_W-1:0]   s2_rad_reg;
    thc_s1_t            s2_side_reg;

    assign ax_sq = s1_reg.ax * s1_reg.ax;

    logic              sq1_valid;
    logic [ROOT_W-1:0] cp_root;
    thc_s1_t           sq1_side;

    thc_sqrt #(
        .SIDE_W($bits(thc_s1_t))
    ) u_sqrt_pitch (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .in_valid(s2_valid_reg),
        .radicand(s2_rad_reg),
        .in_side(s2_side_reg),
        .out_valid(sq1_valid),
        .root(cp_root),
        .out_side(sq1_side)
    );

    // Decide whether roll is computed and set up the division.
    logic [16:0]      aay;
    logic             flag_next;
    logic             s3_valid_reg;
    logic [NUM_W-1:0] s3_num_reg;
    logic [15:0]      s3_den_reg;
    thc_s2_t          s3_side_reg;

    assign aay = sq1_side.ay[16] ? 17'(-sq1_side.ay) : 17'(sq1_side.ay);
    assign flag_next = {1'b0, cp_root} < aay;

    logic             dv_valid;
    logic [QUO_W-1:0] dv_quo;
    thc_s2_t          dv_side;

    thc_div #(
        .SIDE_W($bits(thc_s2_t))
    ) u_div_roll (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .in_valid(s3_valid_reg),
        .dividend(s3_num_reg),
        .divisor(s3_den_reg),
        .in_side(s3_side_reg),
        .out_valid(dv_valid),
        .quotient(dv_quo),
        .out_side(dv_side)
    );

    // Roll sine and the radicand of its cosine.
    logic [31:0]        q_sq;
    logic signed [16:0] sr_next;
    logic               s4_valid_reg;
    logic [RAD_W-1:0]   s4_rad_reg;
    thc_s3_t            s4_side_reg;

    assign q_sq = dv_quo * dv_quo;

    always_comb
    begin
        sr_next = '0;
        if (dv_side.use_div)
            sr_next = dv_side.neg ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});
    end

    logic              sq2_valid;
    logic [ROOT_W-1:0] cr_root;
    thc_s3_t           sq2_side;

    thc_sqrt #(
        .SIDE_W($bits(thc_s3_t))
    ) u_sqrt_roll (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .in_valid(s4_valid_reg),
        .radicand(s4_rad_reg),
        .in_side(s4_side_reg),
        .out_valid(sq2_valid),
        .root(cr_root),
        .out_side(sq2_side)
    );

    // Rotation of the magnetic vector.
    logic               s5_valid_reg;
    logic signed [32:0] s5_p1_reg;
    logic signed [32:0] s5_p2_reg;
    logic signed [32:0] s5_q1_reg;
    logic signed [32:0] s5_q2_reg;
    logic signed [32:0] s5_q3_reg;
    logic signed [16:0] s5_sp_reg;
    logic signed [16:0] s5_cp_reg;
    logic               s5_flag_reg;
    logic signed [15:0] s5_mx_reg;
    logic signed [15:0] s5_my_reg;

    logic                    s6_valid_reg;
    logic signed [TILT_W-1:0] s6_t1_reg;
    logic signed [TILT_W-1:0] s6_t2_reg;
    logic signed [TILT_W-1:0] s6_hx_reg;
    logic signed [TILT_W-1:0] s6_q3s_reg;
    logic                    s6_flag_reg;
    logic signed [15:0]      s6_mx_reg;
    logic signed [15:0]      s6_my_reg;

    logic                    s7_valid_reg;
    logic signed [TILT_W-1:0] s7_hx_reg;
    logic signed [TILT_W-1:0] s7_hy_reg;
    logic                    s7_flag_reg;
    logic signed [15:0]      s7_mx_reg;
    logic signed [15:0]      s7_my_reg;

    logic signed [TILT_W-1:0] t1_next;
    logic signed [TILT_W-1:0] t2_next;

    assign t1_next = s5_p1_reg * s5_sp_reg;
    assign t2_next = s5_p2_reg * s5_cp_reg;

    logic                 tilt_valid;
    logic signed [ZW-1:0] tilt_z;
    logic                 tilt_side;
    logic                 plain_valid;
    logic signed [ZW-1:0] plain_z;
    logic                 plain_side;

    thc_cordic #(
        .IN_W(TILT_W),
        .STAGES(CORDIC_STAGES),
        .SIDE_W(1)
    ) u_cordic_tilt (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .in_valid(s7_valid_reg),
        .y_in(s7_hy_reg),
        .x_in(s7_hx_reg),
        .in_side(s7_flag_reg),
        .out_valid(tilt_valid),
        .angle(tilt_z),
        .out_side(tilt_side)
    );

    thc_cordic #(
        .IN_W(PLAIN_W),
        .STAGES(CORDIC_STAGES),
        .SIDE_W(1)
    ) u_cordic_plain (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .in_valid(s7_valid_reg),
        .y_in(s7_mx_reg),
        .x_in(s7_my_reg),
        .in_side(s7_flag_reg),
        .out_valid(plain_valid),
        .angle(plain_z),
        .out_side(plain_side)
    );

    // Round to output units and add the offset.
    logic signed [ZW-1:0] tilt_round;
    logic signed [ZW-1:0] plain_round;
    logic signed [UW-1:0] tilt_units;
    logic signed [UW-1:0] plain_units;
    logic                 s8_valid_reg;
    logic signed [SW-1:0] s8_tilt_reg;
    logic signed [SW-1:0] s8_plain_reg;
    logic                 s8_flag_reg;

    assign tilt_round = tilt_z + ROUND_HALF;
    assign plain_round = plain_z + ROUND_HALF;
    assign tilt_units = $signed(tilt_round[ZW-1:K]);
    assign plain_units = $signed(plain_round[ZW-1:K]);

    logic        out_valid_reg;
    logic [14:0] tilt_heading_reg;
    logic [14:0] plain_heading_reg;
    logic        flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= sq1_valid;
            s4_valid_reg <= dv_valid;
            s5_valid_reg <= sq2_valid;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= tilt_valid;
            out_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg.ax <= clamp_q15(ax_scaled);
            s1_reg.ay <= clamp_q15(ay_scaled);
            s1_reg.mx <= mag_x;
            s1_reg.my <= mag_y;
            s1_reg.mz <= mag_z;

            s2_rad_reg <= RAD_W'(34'sh0_4000_0000 - ax_sq);
            s2_side_reg <= s1_reg;

            s3_num_reg <= NUM_W'({aay, 15'd0});
            s3_den_reg <= cp_root;
            s3_side_reg.flag <= flag_next;
            s3_side_reg.use_div <= !flag_next && (cp_root != '0);
            s3_side_reg.neg <= sq1_side.ay[16];
            s3_side_reg.cp <= cp_root;
            s3_side_reg.sp <= -sq1_side.ax;
            s3_side_reg.mx <= sq1_side.mx;
            s3_side_reg.my <= sq1_side.my;
            s3_side_reg.mz <= sq1_side.mz;

            s4_rad_reg <= dv_side.use_div ? RAD_W'(32'h4000_0000 - q_sq)
                                          : RAD_W'(32'h4000_0000);
            s4_side_reg.flag <= dv_side.flag;
            s4_side_reg.sr <= sr_next;
            s4_side_reg.cp <= dv_side.cp;
            s4_side_reg.sp <= dv_side.sp;
            s4_side_reg.mx <= dv_side.mx;
            s4_side_reg.my <= dv_side.my;
            s4_side_reg.mz <= dv_side.mz;

            s5_p1_reg <= sq2_side.mx * sq2_side.sr;
            s5_p2_reg <= sq2_side.mz * sq2_side.sr;
            s5_q1_reg <= sq2_side.mx * $signed({1'b0, sq2_side.cp});
            s5_q2_reg <= sq2_side.mz * sq2_side.sp;
            s5_q3_reg <= sq2_side.my * $signed({1'b0, cr_root});
            s5_sp_reg <= sq2_side.sp;
            s5_cp_reg <= $signed({1'b0, sq2_side.cp});
            s5_flag_reg <= sq2_side.flag;
            s5_mx_reg <= sq2_side.mx;
            s5_my_reg <= sq2_side.my;

            s6_t1_reg <= t1_next;
            s6_t2_reg <= t2_next;
            s6_hx_reg <= (TILT_W'(s5_q1_reg) + TILT_W'(s5_q2_reg)) <<< 15;
            s6_q3s_reg <= TILT_W'(s5_q3_reg) <<< 15;
            s6_flag_reg <= s5_flag_reg;
            s6_mx_reg <= s5_mx_reg;
            s6_my_reg <= s5_my_reg;

            s7_hx_reg <= s6_hx_reg;
            s7_hy_reg <= s6_t1_reg + s6_q3s_reg - s6_t2_reg;
            s7_flag_reg <= s6_flag_reg;
            s7_mx_reg <= s6_mx_reg;
            s7_my_reg <= s6_my_reg;

            s8_tilt_reg <= SW'(tilt_units) + SW'(offset_reg);
            s8_plain_reg <= SW'(plain_units);
            s8_flag_reg <= tilt_side;

            tilt_heading_reg <= wrap_angle(s8_tilt_reg);
            plain_heading_reg <= wrap_angle(s8_plain_reg);
            flag_reg <= s8_flag_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign tilt_heading = tilt_heading_reg;
    assign plain_heading = plain_heading_reg;
    assign roll_forced_zero = flag_reg;

    `THC_ASSERT_IMP(a_cordic_lockstep, 1'b1, (tilt_valid == plain_valid) && (!tilt_valid || tilt_side == plain_side), "CORDIC chains out of step")
    `THC_ASSERT_IMP(a_quo_range, dv_valid && dv_side.use_div, dv_quo <= 16'd32768, "roll sine above one")
    `THC_ASSERT_IMP(a_flag_no_roll, sq2_valid && sq2_side.flag, (sq2_side.sr == 17'sd0) && (cr_root == 16'd32768), "forced roll not level")
    `THC_ASSERT_IMP(a_heading_range, out_valid_reg && (FULL <= 32768), (32'(tilt_heading_reg) < FULL) && (32'(plain_heading_reg) < FULL), "heading not wrapped")
    `THC_ASSERT_NXT(a_stall_hold, !en && s7_valid_reg, s7_valid_reg && $stable(s7_hy_reg), "pipeline moved during stall")

endmodule

### rtl/core/thc_sqrt.sv
module thc_sqrt
    import thc_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  radicand,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root,
    output logic [SIDE_W-1:0] out_side
);

    logic [RAD_W-1:0]  u_reg    [0:SQRT_STEPS-1];
    logic [RAD_W:0]    r_reg    [0:SQRT_STEPS-1];
    logic              valid_reg[0:SQRT_STEPS-1];
    logic [SIDE_W-1:0] side_reg [0:SQRT_STEPS-1];

    for (genvar s = 0; s < SQRT_STEPS; s++)
    begin : g_step
        localparam logic [RAD_W+1:0] BIT = (RAD_W+2)'(1) << (RAD_W - 1 - 2 * s);
        logic [RAD_W-1:0]  u_prev;
        logic [RAD_W-1:0]  u_next;
        logic [RAD_W:0]    r_prev;
        logic [RAD_W:0]    r_next;
        logic [RAD_W+1:0]  trial;
        logic              v_prev;
        logic [SIDE_W-1:0] side_prev;

        if (s == 0)
        begin : g_head
            assign u_prev = radicand;
            assign r_prev = '0;
            assign v_prev = in_valid;
            assign side_prev = in_side;
        end
        else
        begin : g_body
            assign u_prev = u_reg[s-1];
            assign r_prev = r_reg[s-1];
            assign v_prev = valid_reg[s-1];
            assign side_prev = side_reg[s-1];
        end

        always_comb
        begin
            trial = {1'b0, r_prev} + BIT;
            if ({2'b00, u_prev} >= trial)
            begin
                u_next = u_prev - trial[RAD_W-1:0];
                r_next = (r_prev >> 1) + BIT[RAD_W:0];
            end
            else
            begin
                u_next = u_prev;
                r_next = r_prev >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (en)
                valid_reg[s] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                u_reg[s] <= u_next;
                r_reg[s] <= r_next;
                side_reg[s] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[SQRT_STEPS-1];
    assign root = r_reg[SQRT_STEPS-1][ROOT_W-1:0];
    assign out_side = side_reg[SQRT_STEPS-1];

endmodule

### rtl/core/thc_div.sv
module thc_div
    import thc_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  dividend,
    input  logic [15:0]       divisor,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quotient,
    output logic [SIDE_W-1:0] out_side
);

    logic [NUM_W-1:0]  rem_reg  [0:QUO_W-1];
    logic [QUO_W-1:0]  q_reg    [0:QUO_W-1];
    logic [15:0]       den_reg  [0:QUO_W-1];
    logic              valid_reg[0:QUO_W-1];
    logic [SIDE_W-1:0] side_reg [0:QUO_W-1];

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_step
        localparam int SH = QUO_W - 1 - s;
        logic [NUM_W-1:0]  rem_prev;
        logic [NUM_W-1:0]  rem_next;
        logic [QUO_W-1:0]  q_prev;
        logic [QUO_W-1:0]  q_next;
        logic [15:0]       den_prev;
        logic [NUM_W:0]    shifted;
        logic              v_prev;
        logic [SIDE_W-1:0] side_prev;

        if (s == 0)
        begin : g_head
            assign rem_prev = dividend;
            assign q_prev = '0;
            assign den_prev = divisor;
            assign v_prev = in_valid;
            assign side_prev = in_side;
        end
        else
        begin : g_body
            assign rem_prev = rem_reg[s-1];
            assign q_prev = q_reg[s-1];
            assign den_prev = den_reg[s-1];
            assign v_prev = valid_reg[s-1];
            assign side_prev = side_reg[s-1];
        end

        always_comb
        begin
            shifted = (NUM_W+1)'(den_prev) << SH;
            if ({1'b0, rem_prev} >= shifted)
            begin
                rem_next = rem_prev - shifted[NUM_W-1:0];
                q_next = q_prev | (QUO_W'(1) << SH);
            end
            else
            begin
                rem_next = rem_prev;
                q_next = q_prev;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (en)
                valid_reg[s] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next;
                q_reg[s] <= q_next;
                den_reg[s] <= den_prev;
                side_reg[s] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign quotient = q_reg[QUO_W-1];
    assign out_side = side_reg[QUO_W-1];

endmodule

### rtl/core/thc_cordic.sv
module thc_cordic
    import thc_pkg::*;
#(
    parameter int IN_W = 16,
    parameter int STAGES = CORDIC_STAGES_DEF,
    parameter int SIDE_W = 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [IN_W-1:0] y_in,
    input  logic signed [IN_W-1:0] x_in,
    input  logic [SIDE_W-1:0]      in_side,
    output logic                   out_valid,
    output logic signed [ZW-1:0]   angle,
    output logic [SIDE_W-1:0]      out_side
);

    localparam int W = IN_W + 3;
    localparam int N = (STAGES < TABLE_LEN) ? STAGES : TABLE_LEN;
    localparam logic signed [ZW-1:0] Z90 = ZW'(90 * (2 ** ZFRAC));

    logic signed [W-1:0]  x_reg    [0:N];
    logic signed [W-1:0]  y_reg    [0:N];
    logic signed [ZW-1:0] z_reg    [0:N];
    logic                 zero_reg [0:N];
    logic                 valid_reg[0:N];
    logic [SIDE_W-1:0]    side_reg [0:N];

    logic signed [W-1:0]  x_ext;
    logic signed [W-1:0]  y_ext;
    logic signed [W-1:0]  x0_next;
    logic signed [W-1:0]  y0_next;
    logic signed [ZW-1:0] z0_next;

    assign x_ext = W'(x_in);
    assign y_ext = W'(y_in);

    // A vector in the left half plane is turned by a quarter turn first.
    always_comb
    begin
        x0_next = x_ext;
        y0_next = y_ext;
        z0_next = '0;
        if (x_ext < 0)
        begin
            if (y_ext >= 0)
            begin
                x0_next = y_ext;
                y0_next = -x_ext;
                z0_next = Z90;
            end
            else
            begin
                x0_next = -y_ext;
                y0_next = x_ext;
                z0_next = -Z90;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= x0_next;
            y_reg[0] <= y0_next;
            z_reg[0] <= z0_next;
            zero_reg[0] <= (x_ext == '0) && (y_ext == '0);
            side_reg[0] <= in_side;
        end
    end

    for (genvar s = 1; s <= N; s++)
    begin : g_stage
        localparam logic signed [ZW-1:0] ATAN = atan_q20(s - 1);
        logic signed [W-1:0]  x_next;
        logic signed [W-1:0]  y_next;
        logic signed [ZW-1:0] z_next;

        always_comb
        begin
            if (y_reg[s-1] > 0)
            begin
                x_next = x_reg[s-1] + (y_reg[s-1] >>> (s - 1));
                y_next = y_reg[s-1] - (x_reg[s-1] >>> (s - 1));
                z_next = z_reg[s-1] + ATAN;
            end
            else
            begin
                x_next = x_reg[s-1] - (y_reg[s-1] >>> (s - 1));
                y_next = y_reg[s-1] + (x_reg[s-1] >>> (s - 1));
                z_next = z_reg[s-1] - ATAN;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (en)
                valid_reg[s] <= valid_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s] <= x_next;
                y_reg[s] <= y_next;
                z_reg[s] <= z_next;
                zero_reg[s] <= zero_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign out_valid = valid_reg[N];
    assign angle = zero_reg[N] ? '0 : z_reg[N];
    assign out_side = side_reg[N];

endmodule

### tb/tb_tilt_compensated_heading.sv
module tb_tilt_compensated_heading;
    import thc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int AFB = ANGLE_FRAC_BITS_DEF;
    localparam int STAGES = CORDIC_STAGES_DEF;
    localparam int LATENCY = 58 + STAGES;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_WORDS = 1000;
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 4'd9;

    typedef struct {
        logic [14:0] tilt;
        logic [14:0] plain;
        logic        flag;
    } heading_t;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] mz;
        bit                 typed;
        heading_t           want;
    } sample_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic signed [15:0]    accel_x;
    logic signed [15:0]    accel_y;
    logic signed [15:0]    accel_z;
    logic signed [15:0]    mag_x;
    logic signed [15:0]    mag_y;
    logic signed [15:0]    mag_z;
    logic                  out_valid;
    logic                  out_ready;
    logic [14:0]           tilt_heading;
    logic [14:0]           plain_heading;
    logic                  roll_forced_zero;

    tilt_compensated_heading dut (.*);

    longint   model_scale;
    longint   model_offset;
    heading_t pending_headings[$];
    int       errors;
    int       idle_mode;
    int       hold_off;
    int       quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sqrt30(longint n);
        longint r;
        longint b;
        longint u;
        r = 0;
        b = longint'(1) << 30;
        if (n <= 0)
            return 0;
        u = n;
        while (b != 0)
        begin
            if (u >= r + b)
            begin
                u = u - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint clamp1(longint v);
        if (v > 32768)
            return 32768;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic longint arc_q20(longint y, longint x);
        longint z;
        longint t;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = longint'(90) << ZFRAC;
            end
            else
            begin
                x = -y;
                y = t;
                z = -(longint'(90) << ZFRAC);
            end
        end
        for (int i = 0; i < STAGES && i < TABLE_LEN; i++)
        begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(atan_q20(i));
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(atan_q20(i));
            end
        end
        return z;
    endfunction

    function automatic longint angle_units(longint z);
        int k;
        k = ZFRAC - AFB;
        return shr(z + (longint'(1) << (k - 1)), k);
    endfunction

    function automatic logic [14:0] wrap_circle(longint a);
        longint full;
        longint r;
        full = longint'(360) << AFB;
        r = a % full;
        if (r < 0)
            r = r + full;
        return r[14:0];
    endfunction

    function automatic heading_t compute_heading(sample_t s);
        heading_t h;
        longint ax;
        longint ay;
        longint mx;
        longint my;
        longint mz;
        longint sp;
        longint cp;
        longint sr;
        longint cr;
        longint hx;
        longint hy;
        ax = clamp1(longint'(s.ax) * model_scale);
        ay = clamp1(longint'(s.ay) * model_scale);
        mx = longint'(s.mx);
        my = longint'(s.my);
        mz = longint'(s.mz);
        sp = -ax;
        cp = sqrt30((longint'(1) << 30) - ax * ax);
        sr = 0;
        cr = 32768;
        h.flag = 1'b0;
        if (cp >= (ay < 0 ? -ay : ay))
        begin
            if (cp != 0)
            begin
                sr = clamp1((ay * 32768) / cp);
                cr = sqrt30((longint'(1) << 30) - sr * sr);
            end
        end
        else
            h.flag = 1'b1;
        hx = (mx * cp + mz * sp) * 32768;
        hy = mx * sr * sp + my * cr * 32768 - mz * sr * cp;
        h.tilt = wrap_circle(angle_units(arc_q20(hy, hx)) + model_offset);
        h.plain = wrap_circle(angle_units(arc_q20(mx, my)));
        return h;
    endfunction

    function automatic bit coin(int percent);
        return $urandom_range(99) < percent;
    endfunction

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_ACCEL_FULL_SCALE)
            model_scale = longint'(value[4:0]);
        else if (idx == REG_HEADING_OFFSET)
            model_offset = longint'($signed(value[14:0]));
    endtask

    task automatic send_sample(sample_t s);
        heading_t h;
        h = compute_heading(s);
        if (s.typed && (h.tilt != s.want.tilt || h.plain != s.want.plain
                || h.flag != s.want.flag))
        begin
            $error("typed row disagrees with predictor: %p vs %p", s.want, h);
            errors++;
        end
        if ((idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) && coin(67))
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (coin(67));
        end
        accel_x <= s.ax;
        accel_y <= s.ay;
        accel_z <= s.az;
        mag_x <= s.mx;
        mag_y <= s.my;
        mag_z <= s.mz;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_headings.push_back(h);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_headings.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10)
            @(posedge clk);
    endtask

    function automatic sample_t raw_sample(int ax, int ay, int az, int mx, int my, int mz);
        sample_t s;
        s.ax = 16'(ax);
        s.ay = 16'(ay);
        s.az = 16'(az);
        s.mx = 16'(mx);
        s.my = 16'(my);
        s.mz = 16'(mz);
        s.typed = 1'b0;
        s.want = '{15'd0, 15'd0, 1'b0};
        return s;
    endfunction

    function automatic sample_t typed_sample(int ax, int ay, int mx, int my, int mz,
                                             int tilt, int plain, bit flag);
        sample_t s;
        s = raw_sample(ax, ay, 0, mx, my, mz);
        s.typed = 1'b1;
        s.want = '{tilt[14:0], plain[14:0], flag};
        return s;
    endfunction

    function automatic int field_value();
        case ($urandom_range(5))
            0: return -32768;
            1: return 32767;
            2: return $signed(16'($urandom_range(65535))) >>> $urandom_range(15);
            default: return $signed(16'($urandom_range(65535)));
        endcase
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        s = raw_sample(field_value(), field_value(), field_value(),
                       field_value(), field_value(), field_value());
        if (coin(60))
        begin
            // Keep the tilt realistic so the roll path is exercised most of the time.
            s.ax = $signed(16'($urandom_range(65535))) >>> (2 + $urandom_range(3));
            s.ay = $signed(16'($urandom_range(65535))) >>> (2 + $urandom_range(3));
        end
        return s;
    endfunction

    sample_t directed[] = '{
        typed_sample(0, 0, 0, 0, 0, 0, 0, 1'b0),
        raw_sample(0, 0, 0, 0, 1000, 0),
        raw_sample(0, 0, 0, 1000, 0, 0),
        raw_sample(-32768, 0, 0, 100, 100, 100),
        typed_sample(32767, 32767, 0, 0, 0, 0, 0, 1'b1),
        raw_sample(0, 0, 0, -1000, 0, 0),
        raw_sample(0, 0, 0, 0, -1000, 0),
        raw_sample(-32768, -32768, -32768, -32768, -32768, -32768),
        raw_sample(32767, 32767, 32767, 32767, 32767, 32767),
        raw_sample(16384, 8000, 0, 500, -300, 700),
        raw_sample(-10000, -5000, 3, -200, 900, -400),
        raw_sample(5000, -16000, 0, 1, -1, 1),
        raw_sample(12000, 13000, -1, 3000, 3000, -3000),
        raw_sample(-1, 1, 0, 32767, -32768, 0)
    };

    initial
    begin
        errors = 0;
        idle_mode = IDLE_NONE;
        hold_off = 0;
        model_scale = longint'(FULL_SCALE_RESET);
        model_offset = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        accel_x = '0;
        accel_y = '0;
        accel_z = '0;
        mag_x = '0;
        mag_y = '0;
        mag_z = '0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_sample(directed[i]);
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    write_register(REG_ACCEL_FULL_SCALE, 16'd1);
                    write_register(REG_HEADING_OFFSET, 16'(-11520));
                end
                1:
                begin
                    write_register(REG_ACCEL_FULL_SCALE, 16'd16);
                    write_register(REG_HEADING_OFFSET, 16'd11520);
                end
                2:
                begin
                    write_register(REG_ACCEL_FULL_SCALE, 16'd0);
                    write_register(REG_HEADING_OFFSET, 16'h7FFF);
                end
                3:
                begin
                    write_register(REG_ACCEL_FULL_SCALE, 16'd31);
                    write_register(REG_NONE, 16'h1234);
                end
                default:
                begin
                    write_register(REG_ACCEL_FULL_SCALE, 16'($urandom_range(16, 1)));
                    write_register(REG_HEADING_OFFSET, 16'($urandom_range(23040) - 11520));
                end
            endcase
            cfg_valid <= 1'b0;
            idle_mode = phase % 4;
            if (phase == 1)
                hold_off = 300;
            for (int n = 0; n < RANDOM_WORDS / 5; n++)
                send_sample(random_sample());
            drain();
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH)
            out_ready <= !coin(67);
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        heading_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_headings.size() == 0)
            begin
                $error("output word with no expected heading");
                errors++;
            end
            else
            begin
                want = pending_headings.pop_front();
                if (tilt_heading !== want.tilt)
                begin
                    $error("tilt_heading expected %0d actual %0d", want.tilt, tilt_heading);
                    errors++;
                end
                if (plain_heading !== want.plain)
                begin
                    $error("plain_heading expected %0d actual %0d", want.plain, plain_heading);
                    errors++;
                end
                if (roll_forced_zero !== want.flag)
                begin
                    $error("roll_forced_zero expected %0d actual %0d", want.flag,
                           roll_forced_zero);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end
endmodule

### files.f
+incdir+rtl/core
rtl/core/thc_pkg.sv
rtl/core/thc_sqrt.sv
rtl/core/thc_div.sv
rtl/core/thc_cordic.sv
rtl/core/tilt_compensated_heading.sv
tb/tb_tilt_compensated_heading.sv
